// ===== hdl/assert_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_ALW(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_ALW(lbl, clk, prop)
`endif
`endif

// ===== hdl/ttsi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ttsi_pkg;

   localparam int DEF_TABLE_DEPTH = 2048;
   localparam int DEF_FRAC_BITS   = 8;

   localparam int SAMPLE_W   = 32;
   localparam int DIST_W     = 33;
   localparam int STEP_W     = 10;
   localparam int ADDR_W     = 11;
   localparam int BASE_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [STEP_W-1:0] STEP_RST = 10'd10;
   localparam logic [ADDR_W-1:0] LAST_RST = 11'd2047;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_DESCENDING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_VALUE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_INDEX = 2'd3;

   typedef struct packed {
      logic                       op;
      logic [ADDR_W-1:0]          entry_addr;
      logic signed [SAMPLE_W-1:0] entry_value;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] reading;
      logic                       clamped;
   } rsp_type;

   typedef struct packed {
      logic write;
      logic convert;
      logic eval;
      logic mult;
      logic div_init;
      logic div_step;
      logic base;
      logic out;
   } cmd_type;

   typedef struct packed {
      logic stop;
      logic interp;
   } sts_type;

endpackage
`default_nettype wire

// ===== hdl/ttsi_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ttsi_datapath
   import ttsi_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   input  wire req_type               req,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output sts_type                    sts,
   output rsp_type                    rsp
);

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int PW  = DIST_W + STEP_W;
   localparam int QW  = STEP_W + FRAC_BITS;
   localparam int MW  = (AW + STEP_W > BASE_W) ? AW + STEP_W : BASE_W;
   localparam int BW  = MW + 2;
   localparam int RW  = (BW + FRAC_BITS + 1 > SAMPLE_W + 2) ? BW + FRAC_BITS + 1 : SAMPLE_W + 2;

   // configuration
   logic                     desc_ff;
   logic signed [BASE_W-1:0] base_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [ADDR_W-1:0]        last_ff;

   // table
   logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // walk state
   logic [AW-1:0]              pos_ff;
   logic [AW-1:0]              p_ff, p_in;
   logic [AW-1:0]              lim_ff, lim_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] prev_ff;
   logic                       up_ff, dn_ff;
   logic                       clamp_ff;

   // interpolation
   logic [DIST_W-1:0] dist_ff, gap_ff;
   logic [PW-1:0]     prod_ff;
   logic [DIST_W-1:0] rem_ff;
   logic [QW-1:0]     low_ff, q_ff;
   logic signed [BW-1:0] sum_ff;
   rsp_type           rsp_ff;

   logic signed [SAMPLE_W-1:0] v;
   logic                       ahead, behind, int_up, int_dn;
   logic signed [SAMPLE_W-1:0] lo, hi;
   logic signed [SAMPLE_W+1:0] dist_w, gap_w;
   logic [DIST_W:0]            trial;
   logic [AW+STEP_W-1:0]       pb;
   logic signed [RW-1:0]       r;

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff <= 1'b0;
         base_ff <= '0;
         step_ff <= STEP_RST;
         last_ff <= LAST_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DESCENDING: desc_ff <= csr_wdata[0];
            CSR_BASE_VALUE: base_ff <= csr_wdata;
            CSR_STEP_SIZE:  step_ff <= csr_wdata[STEP_W-1:0];
            CSR_LAST_INDEX: last_ff <= csr_wdata[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && (32'(req.entry_addr) < 32'(TABLE_DEPTH))) begin
         mem[AW'(req.entry_addr)] <= req.entry_value;
      end
      rd_data_ff <= mem[p_ff];
   end

   always_comb begin
      lim_in = (32'(last_ff) > 32'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1) : AW'(last_ff);
      v      = signed'(rd_data_ff);
      ahead  = desc_ff ? (sample_ff < v) : (sample_ff > v);
      behind = desc_ff ? (sample_ff > v) : (sample_ff < v);
      int_up = up_ff && behind;
      int_dn = dn_ff && ahead;
      sts.interp = int_up || int_dn;
      sts.stop   = !sts.interp && ((!ahead && !behind) || (ahead && (p_ff >= lim_ff))
                   || (behind && (p_ff == '0)));
      lo     = int_up ? prev_ff : v;
      hi     = int_up ? v : prev_ff;
      dist_w = desc_ff ? (34'(lo) - 34'(sample_ff)) : (34'(sample_ff) - 34'(lo));
      gap_w  = desc_ff ? (34'(lo) - 34'(hi)) : (34'(hi) - 34'(lo));
      trial  = {rem_ff, low_ff[QW-1]};
      pb     = p_ff * step_ff;
      r      = (RW'(sum_ff) <<< FRAC_BITS) + signed'(RW'(q_ff));
      p_in   = p_ff;
      if (cmd.convert) begin
         p_in = (pos_ff > lim_in) ? lim_in : pos_ff;
      end else if (cmd.eval) begin
         if (int_up) begin
            p_in = p_ff - AW'(1);
         end else if (!sts.interp && !sts.stop) begin
            p_in = ahead ? p_ff + AW'(1) : p_ff - AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         p_ff   <= '0;
      end else begin
         p_ff <= p_in;
         if (cmd.base) begin
            pos_ff <= p_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.convert) begin
         lim_ff    <= lim_in;
         sample_ff <= req.sample;
         up_ff     <= 1'b0;
         dn_ff     <= 1'b0;
         clamp_ff  <= 1'b0;
         q_ff      <= '0;
      end
      if (cmd.eval) begin
         if (sts.interp) begin
            dist_ff <= dist_w[DIST_W-1:0];
            gap_ff  <= gap_w[DIST_W-1:0];
         end else if (sts.stop) begin
            clamp_ff <= ahead || behind;
         end else begin
            prev_ff <= v;
            up_ff   <= ahead;
            dn_ff   <= !ahead;
         end
      end
      if (cmd.mult) begin
         prod_ff <= dist_ff * step_ff;
      end
      if (cmd.div_init) begin
         rem_ff <= prod_ff[PW-1:STEP_W];
         low_ff <= QW'(prod_ff[STEP_W-1:0]) << FRAC_BITS;
      end
      if (cmd.div_step) begin
         low_ff <= low_ff << 1;
         if (trial >= {1'b0, gap_ff}) begin
            rem_ff <= DIST_W'(trial - {1'b0, gap_ff});
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DIST_W-1:0];
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
      end
      if (cmd.base) begin
         sum_ff <= signed'(BW'(pb)) + BW'(base_ff);
      end
      if (cmd.out) begin
         rsp_ff.clamped <= clamp_ff;
         if (r[RW-1:SAMPLE_W-1] == {(RW-SAMPLE_W+1){r[RW-1]}}) begin
            rsp_ff.reading <= r[SAMPLE_W-1:0];
         end else if (r[RW-1]) begin
            rsp_ff.reading <= {1'b1, {(SAMPLE_W-1){1'b0}}};
         end else begin
            rsp_ff.reading <= {1'b0, {(SAMPLE_W-1){1'b1}}};
         end
      end
   end

   assign rsp = rsp_ff;

   `ASSERT_RST(a_gap_nonzero, clock, reset, cmd.eval && sts.interp |=> gap_ff != '0)
   `ASSERT_RST(a_pos_in_range, clock, reset, cmd.base |=> pos_ff <= lim_ff)
   `ASSERT_RST(a_clamp_no_frac, clock, reset, cmd.base && clamp_ff |-> q_ff == '0)

endmodule
`default_nettype wire

// ===== hdl/ttsi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ttsi_ctrl
   import ttsi_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    op,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy,
   output logic         rsp_strobe
);

   localparam int QW = STEP_W + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_MULT  = 3'd3;
   localparam logic [2:0] S_DINIT = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_BASE  = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (op == OP_CONVERT) begin
                  cmd.convert = 1'b1;
                  state_in    = S_READ;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.stop) begin
               state_in = S_BASE;
            end else if (sts.interp) begin
               state_in = S_MULT;
            end else begin
               state_in = S_READ;
            end
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = CW'(QW);
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            cmd.base = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.out      = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;

   `ASSERT_ALW(a_reset_quiet, clock, reset |=> !rsp_valid_ff && state_ff == S_IDLE)
   `ASSERT_RST(a_strobe_after_out, clock, reset, rsp_valid_ff |-> $past(state_ff) == S_OUT)
   `ASSERT_RST(a_write_idle, clock, reset, cmd.write |-> state_ff == S_IDLE && !cmd.convert)
   `ASSERT_RST(a_div_count, clock, reset, state_ff == S_DIV |-> cnt_ff != '0 && cnt_ff <= CW'(QW))

endmodule
`default_nettype wire

// ===== hdl/tracking_table_search_interp_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// table write: written straight from idle, busy stays low, no result
// convert: walks the table (read, evaluate per entry) from the last stop position, then base and out;
//   multiply, divider init and divider steps are added when the sample falls between two entries
// one item at a time; the next start is taken in the cycle the result is strobed
// synchronous reset clears control, position and configuration registers; table undefined until written
module tracking_table_search_interp_unit
   import ttsi_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   output logic                       rsp_strobe,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   ttsi_ctrl #(
      .FRAC_BITS(FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .op        (req_data.op),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_strobe(rsp_strobe)
   );

   ttsi_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req      (req_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .sts      (sts),
      .rsp      (rsp_data)
   );

endmodule
`default_nettype wire
